// ----- rtl/core/nps_pkg.sv -----
`timescale 1ns / 1ps

package nps_pkg;

  // Width of one coordinate on the ports and in the table.
  localparam int unsigned CoordW   = 16;
  // Width of the entry count reported with each result.
  localparam int unsigned EntriesW = 9;
  // Width of a squared coordinate difference and of a full distance.
  localparam int unsigned SqW      = 2 * CoordW;
  localparam int unsigned DistW    = SqW + 1;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdInsert  = 2'd1,
    CmdRemove  = 2'd2,
    CmdNearest = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  // One stored point.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

  // One command item.
  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } nps_in_t;

  // One result item.
  typedef struct packed {
    status_e             status;
    logic                found;
    logic [CoordW-1:0]   near_x;
    logic [CoordW-1:0]   near_y;
    logic [EntriesW-1:0] entries;
  } nps_out_t;

endpackage

// ----- rtl/core/nearest_point_table_search.sv -----
`timescale 1ns / 1ps

// Channel  | Ports                      | Direction | Handshake
// ---------+----------------------------+-----------+----------------------------------
// command  | start_i, busy_o, item_i    | in        | taken when start_i & !busy_o
// result   | valid_o, result_o          | out       | one-cycle strobe, cannot be held
//
// Clear, insert, and any command on an empty table answer in the cycle after
// the item is taken and leave busy_o low. Remove and nearest on a table of
// N points walk the point memory through one read port and a distance pipeline;
// busy_o stays high until the cycle in which the result strobe rises. Reset
// empties the table at once, with no pass.
module nearest_point_table_search
  import nps_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  nps_in_t  item_i,
  output logic     valid_o,
  output nps_out_t result_o
);

  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StDrain = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  wr_cnt_q, wr_cnt_d;
  logic             found_q, found_d;
  logic             have_best_q, have_best_d;
  logic             p1_vld_q, p1_vld_d;
  logic             p2_vld_q, p3_vld_q;
  logic             valid_q, valid_d;

  // Payload registers.
  cmd_e              cmd_q;
  logic [CoordW-1:0] qx_q, qy_q;
  point_t            rdata_q;
  point_t            pt2_q, pt3_q, best_pt_q;
  logic [CoordW-1:0] dx_q, dy_q;
  logic [SqW-1:0]    sqx_q, sqy_q;
  logic [DistW-1:0]  best_q;
  nps_out_t          res_q, res_d;

  // Point memory.
  point_t           store_q [MAX_POINTS];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  point_t           mem_wdata;

  logic             accept;
  logic             issue;
  logic             last_issue;
  logic             match;
  logic             do_write_back;
  logic [DistW-1:0] dist_sum;
  logic             better;
  logic [CoordW-1:0] dx_d, dy_d;

  assign accept     = start_i && (state_q == StIdle);
  assign issue      = (state_q == StScan);
  assign last_issue = issue && ((CntW'(idx_q) + CntW'(1)) == count_q);

  // Stage one: compare with the query and form absolute differences.
  assign match = (rdata_q.x == qx_q) && (rdata_q.y == qy_q);
  assign do_write_back = p1_vld_q && (cmd_q == CmdRemove) && !match;
  assign dx_d = (rdata_q.x > qx_q) ? (rdata_q.x - qx_q) : (qx_q - rdata_q.x);
  assign dy_d = (rdata_q.y > qy_q) ? (rdata_q.y - qy_q) : (qy_q - rdata_q.y);

  // Stage three: sum of squares and running minimum, first entry wins ties.
  assign dist_sum = DistW'(sqx_q) + DistW'(sqy_q);
  assign better   = !have_best_q || (dist_sum < best_q);

  // Memory write port: append on insert, compact on remove.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_cnt_q[AddrW-1:0];
    mem_wdata = rdata_q;
    if (accept && (item_i.cmd == CmdInsert) && (count_q < CntW'(MAX_POINTS))) begin
      mem_we    = 1'b1;
      mem_waddr = count_q[AddrW-1:0];
      mem_wdata = '{x: item_i.px, y: item_i.py};
    end else if (do_write_back) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_q[idx_q];
  end

  // Sequencer and result formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_cnt_d    = wr_cnt_q;
    found_d     = found_q;
    have_best_d = have_best_q;
    p1_vld_d    = issue;
    valid_d     = 1'b0;
    res_d       = res_q;

    if (do_write_back) begin
      wr_cnt_d = wr_cnt_q + CntW'(1);
    end
    if (p1_vld_q && (cmd_q == CmdRemove) && match) begin
      found_d = 1'b1;
    end
    if (p3_vld_q && better) begin
      have_best_d = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          res_d = '{status: StatusOk, found: 1'b0, near_x: '0, near_y: '0,
                    entries: '0};
          idx_d       = '0;
          wr_cnt_d    = '0;
          found_d     = 1'b0;
          have_best_d = 1'b0;
          case (item_i.cmd)
            CmdClear: begin
              count_d = '0;
              valid_d = 1'b1;
            end
            CmdInsert: begin
              if (count_q < CntW'(MAX_POINTS)) begin
                count_d = count_q + CntW'(1);
              end else begin
                res_d.status = StatusFull;
              end
              res_d.entries = EntriesW'(count_d);
              valid_d       = 1'b1;
            end
            CmdRemove: begin
              if (count_q == '0) begin
                valid_d = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = StatusEmpty;
                valid_d      = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
          endcase
        end
      end
      StScan: begin
        if (last_issue) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      StDrain: begin
        if (!p1_vld_q && !p2_vld_q && !p3_vld_q) begin
          state_d = StIdle;
          valid_d = 1'b1;
          idx_d   = '0;
          if (cmd_q == CmdRemove) begin
            count_d       = wr_cnt_q;
            res_d.found   = found_q;
            res_d.entries = EntriesW'(wr_cnt_q);
          end else begin
            res_d.found   = 1'b1;
            res_d.near_x  = best_pt_q.x;
            res_d.near_y  = best_pt_q.y;
            res_d.entries = EntriesW'(count_q);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      wr_cnt_q    <= '0;
      found_q     <= 1'b0;
      have_best_q <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wr_cnt_q    <= wr_cnt_d;
      found_q     <= found_d;
      have_best_q <= have_best_d;
      p1_vld_q    <= p1_vld_d;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      valid_q     <= valid_d;
    end
  end

  // Datapath registers: query capture, distance pipeline, best point.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i.cmd;
      qx_q  <= item_i.px;
      qy_q  <= item_i.py;
    end
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    pt2_q <= rdata_q;
    sqx_q <= SqW'(dx_q) * SqW'(dx_q);
    sqy_q <= SqW'(dy_q) * SqW'(dy_q);
    pt3_q <= pt2_q;
    if (p3_vld_q && better) begin
      best_q    <= dist_sum;
      best_pt_q <= pt3_q;
    end
    res_q <= res_d;
  end

  assign busy_o   = (state_q != StIdle);
  assign valid_o  = valid_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // The table never holds more points than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_POINTS))
    else $error("point count exceeds table size");

  // A result is only delivered once the block has finished its walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // Reads during a walk stay inside the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CntW'(idx_q) < count_q))
    else $error("walk index beyond point count");

  // Compaction writes stay inside the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write_back |-> (wr_cnt_q < count_q))
    else $error("compaction write index out of range");

  // A walk over a non-empty table makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (count_q != '0) &&
     ((item_i.cmd == CmdRemove) || (item_i.cmd == CmdNearest))) |=> busy_o)
    else $error("walk command did not start");
`endif

endmodule

// ----- tb/tb_nearest_point_table_search.sv -----
`timescale 1ns / 1ps

module tb_nearest_point_table_search
  import nps_pkg::*;
();

  localparam int unsigned TableDepth  = 256;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned DrainCycles = TableDepth + 40;
  localparam int unsigned CycleLimit  = 3_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  nps_in_t  item_i;
  logic     valid_o;
  nps_out_t result_o;

  int unsigned items_sent;
  int unsigned cycles;

  // Shadow copy of the point table. Each accepted command updates it and
  // queues the result that the block must return for that command.
  class table_tracker;
    point_t      pts[TableDepth];
    int unsigned count;
    nps_out_t    pending_results[$];
    int unsigned errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function automatic void apply_command(nps_in_t it);
      nps_out_t         res;
      int unsigned      wr;
      logic [CoordW-1:0] dx;
      logic [CoordW-1:0] dy;
      logic [SqW-1:0]   sx;
      logic [SqW-1:0]   sy;
      logic [DistW-1:0] cand_dist;
      logic [DistW-1:0] best;
      res        = '0;
      res.status = StatusOk;
      best       = '0;
      case (it.cmd)
        CmdClear: begin
          count = 0;
        end
        CmdInsert: begin
          if (count >= TableDepth) begin
            res.status = StatusFull;
          end else begin
            pts[count].x = it.px;
            pts[count].y = it.py;
            count++;
          end
        end
        CmdRemove: begin
          // Drop every equal entry and close the gaps in order.
          wr = 0;
          for (int unsigned i = 0; i < count; i++) begin
            if (pts[i].x == it.px && pts[i].y == it.py) begin
              res.found = 1'b1;
            end else begin
              pts[wr] = pts[i];
              wr++;
            end
          end
          count = wr;
        end
        default: begin
          if (count == 0) begin
            res.status = StatusEmpty;
          end else begin
            // Strictly smaller distance replaces, so the earliest entry wins ties.
            for (int unsigned i = 0; i < count; i++) begin
              dx        = (pts[i].x > it.px) ? pts[i].x - it.px : it.px - pts[i].x;
              dy        = (pts[i].y > it.py) ? pts[i].y - it.py : it.py - pts[i].y;
              sx        = dx * dx;
              sy        = dy * dy;
              cand_dist = sx + sy;
              if (i == 0 || cand_dist < best) begin
                best       = cand_dist;
                res.near_x = pts[i].x;
                res.near_y = pts[i].y;
              end
            end
            res.found = 1'b1;
          end
        end
      endcase
      res.entries = count[EntriesW-1:0];
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ns: result check failed: %s", $time, msg);
      errors++;
    endtask

    task check_result(nps_out_t got);
      nps_out_t exp;
      if (pending_results.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
        if (got.found !== exp.found)
          report($sformatf("found %0b, expected %0b", got.found, exp.found));
        if (got.near_x !== exp.near_x)
          report($sformatf("near_x %0d, expected %0d", got.near_x, exp.near_x));
        if (got.near_y !== exp.near_y)
          report($sformatf("near_y %0d, expected %0d", got.near_y, exp.near_y));
        if (got.entries !== exp.entries)
          report($sformatf("entries %0d, expected %0d", got.entries, exp.entries));
      end
    endtask
  endclass

  table_tracker tracker = new();

  nearest_point_table_search #(
    .MAX_POINTS(TableDepth)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      tracker.check_result(result_o);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[nearest_point_table_search] ERROR");
      $finish;
    end
  end

  function automatic nps_in_t make_item(cmd_e c, logic [CoordW-1:0] x,
                                        logic [CoordW-1:0] y);
    nps_in_t it;
    it.cmd = c;
    it.px  = x;
    it.py  = y;
    return it;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send(nps_in_t it, int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      item_i  <= make_item(cmd_e'($urandom_range(0, 3)), CoordW'($urandom),
                           CoordW'($urandom));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    tracker.apply_command(it);
    items_sent++;
  endtask

  // Hold off the sender until the block has answered everything.
  task automatic wait_all_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Coordinates either anywhere or inside a tiny window, where ties and
  // exact matches become likely.
  function automatic logic [CoordW-1:0] pick_coord(bit narrow, logic [CoordW-1:0] base);
    if (narrow) return base + CoordW'($urandom_range(0, 7));
    return CoordW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CoordW-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CoordW'(65535 - 7);
    return CoordW'($urandom_range(0, 65535 - 7));
  endfunction

  // One random episode: start from a cleared table, fill it to the given
  // size, then run a mix of queries, removes, inserts and clears on it.
  task automatic run_episode(int unsigned fill, int unsigned ops, bit burst);
    bit               narrow;
    logic [CoordW-1:0] base;
    int unsigned      r;
    int unsigned      idx;
    nps_in_t          it;
    narrow = ($urandom_range(0, 1) == 1);
    base   = pick_base();
    send(make_item(CmdClear, CoordW'($urandom), CoordW'($urandom)), pick_gap(burst));
    for (int unsigned i = 0; i < fill; i++) begin
      send(make_item(CmdInsert, pick_coord(narrow, base), pick_coord(narrow, base)),
           pick_gap(burst));
    end
    for (int unsigned i = 0; i < ops; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it = make_item(CmdNearest, pick_coord(narrow, base), pick_coord(narrow, base));
      end else if (r < 50) begin
        it = make_item(CmdNearest, ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000,
                       ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000);
      end else if (r < 70) begin
        // Removes mostly target a point that is stored.
        if (tracker.count != 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, tracker.count - 1);
          it  = make_item(CmdRemove, tracker.pts[idx].x, tracker.pts[idx].y);
        end else begin
          it = make_item(CmdRemove, pick_coord(narrow, base), pick_coord(narrow, base));
        end
      end else if (r < 95) begin
        it = make_item(CmdInsert, pick_coord(narrow, base), pick_coord(narrow, base));
      end else begin
        it = make_item(CmdClear, CoordW'($urandom), CoordW'($urandom));
      end
      send(it, pick_gap(burst));
    end
  endtask

  initial begin
    int unsigned fill;
    int unsigned r;
    int unsigned episode;
    int unsigned base_items;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    items_sent = 0;
    cycles     = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, coordinate extremes, duplicates, ties, compaction.
    send(make_item(CmdClear,   16'h0000, 16'h0000), 0);
    send(make_item(CmdNearest, 16'h1234, 16'h4321), 0);
    send(make_item(CmdRemove,  16'h0000, 16'h0000), 0);
    send(make_item(CmdInsert,  16'h0000, 16'h0000), 0);
    send(make_item(CmdInsert,  16'hFFFF, 16'hFFFF), 0);
    send(make_item(CmdInsert,  16'h0000, 16'hFFFF), 1);
    send(make_item(CmdNearest, 16'hFFFF, 16'h0000), 0);
    send(make_item(CmdNearest, 16'hFFFF, 16'hFFFF), 2);
    send(make_item(CmdInsert,  16'd100,  16'd200),  0);
    send(make_item(CmdInsert,  16'd100,  16'd200),  0);
    send(make_item(CmdRemove,  16'd100,  16'd200),  0);
    send(make_item(CmdRemove,  16'd1,    16'd1),    0);
    send(make_item(CmdInsert,  16'd10,   16'd10),   0);
    send(make_item(CmdInsert,  16'd20,   16'd20),   0);
    send(make_item(CmdNearest, 16'd15,   16'd15),   0);
    send(make_item(CmdRemove,  16'h0000, 16'h0000), 3);
    send(make_item(CmdNearest, 16'h0000, 16'h0000), 0);
    send(make_item(CmdClear,   16'hFFFF, 16'hFFFF), 0);
    send(make_item(CmdNearest, 16'h0000, 16'h0000), 0);
    send(make_item(CmdInsert,  16'hAAAA, 16'h5555), 0);
    send(make_item(CmdInsert,  16'h5555, 16'hAAAA), 0);
    send(make_item(CmdNearest, 16'h8000, 16'h8000), 0);
    wait_all_results();

    // Fill the table to the limit, then run it into the full case.
    base_items = items_sent;
    run_episode(TableDepth, 0, 1'b0);
    for (int unsigned i = 0; i < 3; i++) begin
      send(make_item(CmdInsert, CoordW'($urandom), CoordW'($urandom)), pick_gap(1'b0));
    end
    send(make_item(CmdNearest, CoordW'($urandom), CoordW'($urandom)), 0);
    send(make_item(CmdRemove, tracker.pts[TableDepth - 1].x,
                   tracker.pts[TableDepth - 1].y), 0);
    send(make_item(CmdInsert, 16'hFFFF, 16'h0000), 0);
    send(make_item(CmdInsert, 16'h0000, 16'hFFFF), 0);
    send(make_item(CmdNearest, 16'hFFFF, 16'h0000), pick_gap(1'b0));

    // Random episodes, mostly on small tables.
    episode = 0;
    while (items_sent - base_items < RandomItems) begin
      if (episode % 6 == 0) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 85) fill = $urandom_range(0, 12);
      else if (r < 97) fill = $urandom_range(13, 64);
      else fill = $urandom_range(200, TableDepth);
      run_episode(fill, $urandom_range(10, 30), ($urandom_range(0, 3) == 0));
      episode++;
    end

    // Let every answer arrive, then watch for stray strobes.
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("[nearest_point_table_search] OK");
    end else begin
      $display("[nearest_point_table_search] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/nps_pkg.sv
rtl/core/nearest_point_table_search.sv
tb/tb_nearest_point_table_search.sv
